>>> hdl/hbsf_pkg.sv
// Package for the HDLC byte-stuffing framer: command codes, burst types,
// reset values and the FCS and stuffing functions. No dependencies.
package hbsf_pkg;

    localparam int MaxBurst   = 5;
    localparam int BurstWidth = 8 * MaxBurst;
    localparam int CountWidth = $clog2(MaxBurst + 1);

    localparam logic [15:0] FcsInit   = 16'hFFFF;
    localparam logic [15:0] FcsPoly   = 16'h8408;
    localparam logic [7:0]  StuffMask = 8'h20;
    localparam logic [7:0]  FlagReset = 8'h7E;
    localparam logic [7:0]  EscReset  = 8'h7D;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_DATA  = 2'd1,
        CMD_END   = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic {
        REG_FLAG   = 1'b0,
        REG_ESCAPE = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [BurstWidth-1:0] bytes;
        logic [CountWidth-1:0] count;
        logic                  done;
    } burst_t;

    typedef struct packed {
        logic [15:0] bytes;
        logic [1:0]  len;
    } pair_t;

    function automatic logic [15:0] fcs_fold(input logic [15:0] fcs, input logic [7:0] b);
        logic [15:0] v;
        v = fcs ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            v = v[0] ? ((v >> 1) ^ FcsPoly) : (v >> 1);
        end
        return v;
    endfunction

    function automatic pair_t stuff(input logic [7:0] b, input logic [7:0] flag,
                                    input logic [7:0] esc);
        pair_t p;
        if (b == flag || b == esc) begin
            p.bytes = {b ^ StuffMask, esc};
            p.len   = 2'd2;
        end else begin
            p.bytes = {8'h00, b};
            p.len   = 2'd1;
        end
        return p;
    endfunction

endpackage

>>> hdl/hbsf_encode.sv
// Frame encoder: holds the running FCS and frame state, turns one command
// into a burst of up to five line bytes. Depends on hbsf_pkg.
module hbsf_encode (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  logic [1:0]       cmd,
    input  logic [7:0]       data_byte,
    input  logic [7:0]       flag_byte,
    input  logic [7:0]       escape_byte,
    output hbsf_pkg::burst_t burst
);

    logic [15:0] fcs_reg, fcs_next;
    logic        open_reg, open_next;
    hbsf_pkg::pair_t p_data, p_lo, p_hi;
    logic [hbsf_pkg::BurstWidth-1:0] vec;
    logic [hbsf_pkg::CountWidth-1:0] n;

    always_comb begin
        p_data    = hbsf_pkg::stuff(data_byte, flag_byte, escape_byte);
        p_lo      = hbsf_pkg::stuff(fcs_reg[7:0], flag_byte, escape_byte);
        p_hi      = hbsf_pkg::stuff(fcs_reg[15:8], flag_byte, escape_byte);
        vec       = '0;
        n         = '0;
        fcs_next  = fcs_reg;
        open_next = open_reg;
        burst.done = 1'b0;
        case (hbsf_pkg::cmd_t'(cmd))
            hbsf_pkg::CMD_START: begin
                vec       = hbsf_pkg::BurstWidth'(flag_byte)
                          | (hbsf_pkg::BurstWidth'(p_data.bytes) << 8);
                n         = hbsf_pkg::CountWidth'(p_data.len) + 1'b1;
                fcs_next  = hbsf_pkg::fcs_fold(hbsf_pkg::FcsInit, data_byte);
                open_next = 1'b1;
            end
            hbsf_pkg::CMD_DATA: begin
                if (open_reg) begin
                    vec      = hbsf_pkg::BurstWidth'(p_data.bytes);
                    n        = hbsf_pkg::CountWidth'(p_data.len);
                    fcs_next = hbsf_pkg::fcs_fold(fcs_reg, data_byte);
                end
            end
            hbsf_pkg::CMD_END: begin
                if (open_reg) begin
                    vec = hbsf_pkg::BurstWidth'(p_lo.bytes)
                        | (hbsf_pkg::BurstWidth'(p_hi.bytes) << {p_lo.len, 3'b000})
                        | (hbsf_pkg::BurstWidth'(flag_byte)
                           << {3'(p_lo.len) + 3'(p_hi.len), 3'b000});
                    n          = hbsf_pkg::CountWidth'(p_lo.len)
                               + hbsf_pkg::CountWidth'(p_hi.len) + 1'b1;
                    burst.done = 1'b1;
                    fcs_next   = hbsf_pkg::FcsInit;
                    open_next  = 1'b0;
                end
            end
            default: begin
            end
        endcase
        burst.bytes = vec;
        burst.count = n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fcs_reg  <= hbsf_pkg::FcsInit;
            open_reg <= 1'b0;
        end else if (accept) begin
            fcs_reg  <= fcs_next;
            open_reg <= open_next;
        end
    end

endmodule

>>> hdl/hbsf_burst.sv
// Output serializer: holds one burst and shifts it out one byte per transfer.
// Depends on hbsf_pkg.
module hbsf_burst (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  hbsf_pkg::burst_t burst,
    output logic             free,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tlast,
    output logic             m_tuser
);

    logic [hbsf_pkg::BurstWidth-1:0] bytes_reg;
    logic [hbsf_pkg::CountWidth-1:0] cnt_reg;
    logic                            done_reg;
    logic                            single;

    assign single   = (cnt_reg == hbsf_pkg::CountWidth'(1));
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = bytes_reg[7:0];
    assign m_tlast  = single;
    assign m_tuser  = single && done_reg;
    assign free     = (cnt_reg == '0) || (single && m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (load) begin
            cnt_reg <= burst.count;
        end else if (m_tvalid && m_tready) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            bytes_reg <= burst.bytes;
            done_reg  <= burst.done;
        end else if (m_tvalid && m_tready) begin
            bytes_reg <= bytes_reg >> 8;
        end
    end

endmodule

>>> hdl/hdlc_byte_stuff_framer_core.sv
// HDLC byte-stuffing framer with reflected CRC-16 FCS.
// The first line byte is valid in the cycle after the input transfer.
// An item that yields N bytes (0 to 5) occupies the output serializer until its
// last byte transfers; the next item is taken in the cycle its last byte transfers.
// Reset: aresetn synchronous, active low; closes the frame, presets the FCS to all
// ones and returns flag and escape to their default bytes. Depends on hbsf_pkg,
// hbsf_encode, hbsf_burst.
module hdlc_byte_stuff_framer_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic [1:0] s_tuser,   // [1:0] cmd
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,
    output logic       m_tuser,   // [0] frame_done
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    logic [7:0]       flag_reg;
    logic [7:0]       esc_reg;
    logic             accept;
    hbsf_pkg::burst_t burst;

    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_reg <= hbsf_pkg::FlagReset;
            esc_reg  <= hbsf_pkg::EscReset;
        end else if (cfg_valid) begin
            case (hbsf_pkg::reg_index_t'(cfg_index))
                hbsf_pkg::REG_FLAG:   flag_reg <= cfg_data;
                hbsf_pkg::REG_ESCAPE: esc_reg  <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    hbsf_encode u_encode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .cmd         (s_tuser),
        .data_byte   (s_tdata),
        .flag_byte   (flag_reg),
        .escape_byte (esc_reg),
        .burst       (burst)
    );

    hbsf_burst u_burst (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .burst    (burst),
        .free     (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

>>> hdl/hbsf_checker.sv
// Port-level checker for the HDLC framer, bound to the top level.
// Depends on hbsf_pkg and hdlc_byte_stuff_framer_core.
module hbsf_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [1:0] s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       m_tuser
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output transfer changed while stalled");

    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("closing flag not on final byte");

    a_start_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == hbsf_pkg::CMD_START |=> m_tvalid && !m_tlast)
        else $error("start did not open a multi-byte burst");

    a_burst_cont: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && (m_tlast || !s_tready))
        else $error("burst broken before final byte");

endmodule

bind hdlc_byte_stuff_framer_core hbsf_checker u_hbsf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
